/* hdl/fwo_pkg.sv */
`default_nettype none
package fwo_pkg;

    localparam int COUNT_BITS_DEF  = 16;
    localparam int ANGLE_STEPS_DEF = 24;

    // multiplier operand and product widths
    localparam int MUL_A_W = 64;
    localparam int MUL_B_W = 35;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MM_PER_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_X      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y      = 2'd3;

    localparam logic [23:0] MM_PER_COUNT_RST = 24'd51472;
    localparam logic [31:0] TURN_GAIN_RST    = 32'd174992640;
    localparam logic [31:0] START_X_RST      = 32'hFE3E_0000; // -450 mm
    localparam logic [31:0] START_Y_RST      = 32'h01F4_0000; // 500 mm

    localparam logic [31:0] EIGHTH_TURN  = 32'h2000_0000;    // PI/4
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [34:0] CORDIC_K     = 35'h0_26DD_3B6A;

    // multiply sequence of one update
    typedef enum logic [2:0] {
        OP_D13, OP_D24, OP_DIFF, OP_TURN, OP_XC, OP_XS, OP_YC, OP_YS
    } op_t;

    typedef struct packed {
        logic edge_en;
        logic cord_load;
        logic cord_step;
        logic mul_start;
        op_t  mul_op;
        logic mul_capture;
        logic commit;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic cord_last;
        logic mul_done;
    } status_t;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* hdl/fwo_mult.sv */
`default_nettype none
// radix-2 shift-add signed multiplier, one operand bit per cycle
module fwo_mult (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [fwo_pkg::MUL_A_W-1:0] a,
    input  wire logic [fwo_pkg::MUL_B_W-1:0] b,
    output logic                             done,
    output logic [fwo_pkg::MUL_P_W-1:0]      prod
);
    import fwo_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_B_W - 1);

    logic [MUL_P_W-1:0] acc_reg;
    logic [MUL_P_W-1:0] ash_reg;
    logic [MUL_B_W-1:0] b_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [MUL_P_W-1:0] addend;

    assign addend = b_reg[0] ? ash_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            ash_reg <= {{(MUL_P_W-MUL_A_W){a[MUL_A_W-1]}}, a};
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            // sign bit of b carries negative weight
            if (cnt_reg == CNT_LAST)
                acc_reg <= acc_reg - addend;
            else
                acc_reg <= acc_reg + addend;
            ash_reg <= {ash_reg[MUL_P_W-2:0], 1'b0};
            b_reg   <= {b_reg[MUL_B_W-1], b_reg[MUL_B_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule
`default_nettype wire

/* hdl/fwo_ctrl.sv */
`default_nettype none
module fwo_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             mode,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output fwo_pkg::cmd_t         cmd,
    input  wire fwo_pkg::status_t status
);
    import fwo_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CLOAD, S_CRUN, S_MSTART, S_MWAIT, S_COMMIT, S_DONE
    } state_t;

    state_t state_reg;
    op_t    op_reg;
    logic   ov_reg;
    logic   accept;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !ov_reg || out_ready;
    assign out_valid = ov_reg;

    always_comb
    begin
        cmd             = '0;
        cmd.mul_op      = op_reg;
        cmd.edge_en     = accept && !mode;
        cmd.cord_load   = (state_reg == S_CLOAD);
        cmd.cord_step   = (state_reg == S_CRUN);
        cmd.mul_start   = (state_reg == S_MSTART);
        cmd.mul_capture = (state_reg == S_MWAIT) && status.mul_done;
        cmd.commit      = (state_reg == S_COMMIT);
        cmd.out_load    = (state_reg == S_DONE) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_D13;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg    <= OP_D13;
                        state_reg <= mode ? S_CLOAD : S_DONE;
                    end
                end
                S_CLOAD:
                    state_reg <= S_CRUN;
                S_CRUN:
                begin
                    if (status.cord_last)
                        state_reg <= S_MSTART;
                end
                S_MSTART:
                    state_reg <= S_MWAIT;
                S_MWAIT:
                begin
                    if (status.mul_done)
                    begin
                        unique case (op_reg)
                            OP_D13:  op_reg <= OP_D24;
                            OP_D24:  op_reg <= OP_DIFF;
                            OP_DIFF: op_reg <= OP_TURN;
                            OP_TURN: op_reg <= OP_XC;
                            OP_XC:   op_reg <= OP_XS;
                            OP_XS:   op_reg <= OP_YC;
                            OP_YC:   op_reg <= OP_YS;
                            OP_YS:   op_reg <= OP_D13;
                        endcase
                        state_reg <= (op_reg == OP_YS) ? S_COMMIT : S_MSTART;
                    end
                end
                S_COMMIT:
                    state_reg <= S_DONE;
                S_DONE:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

/* hdl/fwo_datapath.sv */
`default_nettype none
module fwo_datapath #(
    parameter int COUNT_BITS  = fwo_pkg::COUNT_BITS_DEF,
    parameter int ANGLE_STEPS = fwo_pkg::ANGLE_STEPS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [fwo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fwo_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [1:0]                     wheel,
    input  wire logic                           up,
    input  wire fwo_pkg::cmd_t                  cmd,
    output fwo_pkg::status_t                    status,
    output logic signed [31:0]                  pos_x,
    output logic signed [31:0]                  pos_y,
    output logic [31:0]                         heading
);
    import fwo_pkg::*;

    localparam int STEPS = (ANGLE_STEPS < 32) ? ANGLE_STEPS : 32;
    localparam logic [4:0] STEP_LAST = 5'(STEPS - 1);
    localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
    localparam int SH_W  = MUL_P_W - 30;
    localparam int SUM_W = SH_W + 1;

    logic [23:0] mm_reg;
    logic [31:0] gain_reg;
    logic signed [COUNT_BITS-1:0] cnt_reg [4];
    logic signed [31:0] x_reg, y_reg;
    logic [31:0]        hd_reg;

    logic signed [MUL_A_W-1:0] d13_reg, d24_reg, diff_reg;
    logic [31:0]               hinc_reg;
    logic signed [SH_W-1:0]    accx_reg, accy_reg;

    logic signed [MUL_B_W-1:0] cx_reg, cy_reg;
    logic signed [33:0]        cz_reg;
    logic                      flip_reg;
    logic [4:0]                idx_reg;

    logic signed [31:0] px_reg, py_reg;
    logic [31:0]        ph_reg;

    // multiplier hookup
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               mul_done;
    logic [MUL_P_W-1:0] mul_p;
    logic signed [SH_W-1:0] prod_sh;

    logic signed [MUL_A_W-1:0] c0, c1, c2, c3;
    logic signed [MUL_B_W-1:0] cos_v, sin_v, mm_b, gain_b;
    logic [31:0] ang, ang_f;
    logic        flip_n;
    logic signed [MUL_B_W-1:0] xs, ys;
    logic signed [33:0]        at;
    logic signed [SUM_W-1:0]   sum_x, sum_y;
    logic signed [31:0]        sat_x, sat_y;

    fwo_mult u_mult (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_p)
    );

    assign c0 = MUL_A_W'(cnt_reg[0]);
    assign c1 = MUL_A_W'(cnt_reg[1]);
    assign c2 = MUL_A_W'(cnt_reg[2]);
    assign c3 = MUL_A_W'(cnt_reg[3]);
    assign mm_b   = {{(MUL_B_W-24){1'b0}}, mm_reg};
    assign gain_b = {{(MUL_B_W-32){1'b0}}, gain_reg};
    assign cos_v  = flip_reg ? -cx_reg : cx_reg;
    assign sin_v  = flip_reg ? -cy_reg : cy_reg;
    assign prod_sh = mul_p[MUL_P_W-1:30];

    always_comb
    begin
        unique case (cmd.mul_op)
            OP_D13:  begin mul_a = c2 - c0;           mul_b = mm_b;   end
            OP_D24:  begin mul_a = c3 - c1;           mul_b = mm_b;   end
            OP_DIFF: begin mul_a = c0 + c1 + c2 + c3; mul_b = mm_b;   end
            OP_TURN: begin mul_a = diff_reg;          mul_b = gain_b; end
            OP_XC:   begin mul_a = -d24_reg;          mul_b = cos_v;  end
            OP_XS:   begin mul_a = d13_reg;           mul_b = sin_v;  end
            OP_YC:   begin mul_a = -d13_reg;          mul_b = cos_v;  end
            OP_YS:   begin mul_a = d24_reg;           mul_b = sin_v;  end
            default: begin mul_a = '0;                mul_b = '0;     end
        endcase
    end

    // CORDIC angle prep: fold the back half plane by a half turn
    assign ang    = hd_reg + EIGHTH_TURN;
    assign flip_n = ang[31] ^ (ang[30]);
    assign ang_f  = flip_n ? {~ang[31], ang[30:0]} : ang;
    assign xs = cx_reg >>> idx_reg;
    assign ys = cy_reg >>> idx_reg;
    assign at = {2'b00, atan_lut(idx_reg)};

    assign status.cord_last = cmd.cord_step && (idx_reg == STEP_LAST);
    assign status.mul_done  = mul_done;

    // pose accumulate with saturation to 32 bits
    assign sum_x = SUM_W'(x_reg) + SUM_W'(accx_reg);
    assign sum_y = SUM_W'(y_reg) + SUM_W'(accy_reg);

    always_comb
    begin
        if (sum_x > SUM_W'(32'sh7FFF_FFFF))
            sat_x = 32'sh7FFF_FFFF;
        else if (sum_x < -SUM_W'(33'sh0_8000_0000))
            sat_x = 32'sh8000_0000;
        else
            sat_x = sum_x[31:0];
        if (sum_y > SUM_W'(32'sh7FFF_FFFF))
            sat_y = 32'sh7FFF_FFFF;
        else if (sum_y < -SUM_W'(33'sh0_8000_0000))
            sat_y = 32'sh8000_0000;
        else
            sat_y = sum_y[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mm_reg   <= MM_PER_COUNT_RST;
            gain_reg <= TURN_GAIN_RST;
            x_reg    <= START_X_RST;
            y_reg    <= START_Y_RST;
            hd_reg   <= '0;
            for (int i = 0; i < 4; i++)
                cnt_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MM_PER_COUNT: mm_reg   <= cfg_data[23:0];
                    REG_TURN_GAIN:    gain_reg <= cfg_data;
                    REG_START_X:      x_reg    <= cfg_data;
                    REG_START_Y:      y_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.edge_en)
            begin
                if (up)
                begin
                    if (cnt_reg[wheel] != CNT_MAX)
                        cnt_reg[wheel] <= cnt_reg[wheel] + 1'b1;
                end
                else if (cnt_reg[wheel] != CNT_MIN)
                    cnt_reg[wheel] <= cnt_reg[wheel] - 1'b1;
            end
            if (cmd.commit)
            begin
                x_reg  <= sat_x;
                y_reg  <= sat_y;
                hd_reg <= hd_reg + hinc_reg;
                for (int i = 0; i < 4; i++)
                    cnt_reg[i] <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cord_load)
        begin
            cx_reg   <= CORDIC_K;
            cy_reg   <= '0;
            cz_reg   <= 34'(signed'(ang_f));
            flip_reg <= flip_n;
            idx_reg  <= '0;
        end
        else if (cmd.cord_step)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (!cz_reg[33])
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - at;
            end
            else
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + at;
            end
        end

        if (cmd.mul_capture)
        begin
            unique case (cmd.mul_op)
                OP_D13:  d13_reg  <= mul_p[MUL_A_W:1];
                OP_D24:  d24_reg  <= mul_p[MUL_A_W:1];
                OP_DIFF: diff_reg <= mul_p[MUL_A_W-1:0];
                OP_TURN: hinc_reg <= mul_p[55:24];
                OP_XC:   accx_reg <= prod_sh;
                OP_XS:   accx_reg <= accx_reg - prod_sh;
                OP_YC:   accy_reg <= prod_sh;
                OP_YS:   accy_reg <= accy_reg + prod_sh;
                default: ;
            endcase
        end

        if (cmd.out_load)
        begin
            px_reg <= x_reg;
            py_reg <= y_reg;
            ph_reg <= hd_reg;
        end
    end

    assign pos_x   = px_reg;
    assign pos_y   = py_reg;
    assign heading = ph_reg;

endmodule
`default_nettype wire

/* hdl/four_wheel_omni_odometry.sv */
`default_nettype none
// Odometry for a four wheel X-drive robot. An edge transaction (mode 0) steps
// one wheel count up or down, saturating at the signed COUNT_BITS range, and
// goes straight to the output load. An update transaction (mode 1) runs an
// iterative CORDIC for sin/cos of heading + 45 deg, then eight products on one
// shared shift-add multiplier, which scale counts to mm, form the heading step
// and rotate the travel into x/y. One transaction is processed at a time; each
// returns the pose (Q16.16 mm x/y, 32-bit binary angle heading) as it stands
// after that transaction, held in an output register so the next transaction
// is taken while the result waits. Config writes (0 mm_per_count, 1 turn_gain,
// 2 start_x, 3 start_y) are applied at once; start writes also load the
// position.
module four_wheel_omni_odometry #(
    parameter int COUNT_BITS  = fwo_pkg::COUNT_BITS_DEF,
    parameter int ANGLE_STEPS = fwo_pkg::ANGLE_STEPS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // config write port
    input  wire logic                           cfg_we,
    input  wire logic [fwo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fwo_pkg::CFG_DATA_W-1:0] cfg_data,
    // input transaction
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           mode,
    input  wire logic [1:0]                     wheel,
    input  wire logic                           up,
    // result transaction
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [31:0]                  pos_x,
    output logic signed [31:0]                  pos_y,
    output logic [31:0]                         heading
);
    import fwo_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: accept, CORDIC run, multiply sequence, commit, output load
    fwo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // counts, pose, config registers, CORDIC and multiplier
    fwo_datapath #(
        .COUNT_BITS  (COUNT_BITS),
        .ANGLE_STEPS (ANGLE_STEPS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .wheel     (wheel),
        .up        (up),
        .cmd       (cmd),
        .status    (status),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .heading   (heading)
    );

endmodule
`default_nettype wire

/* dv/four_wheel_omni_odometry_test.sv */
`default_nettype none
module four_wheel_omni_odometry_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fwo_pkg::*;

    // DUT hookup
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  mode;
    logic [1:0]            wheel;
    logic                  up;
    logic                  out_valid;
    logic                  out_ready;
    logic signed [31:0]    pos_x;
    logic signed [31:0]    pos_y;
    logic [31:0]           heading;

    four_wheel_omni_odometry u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .wheel     (wheel),
        .up        (up),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .heading   (heading)
    );

    localparam int      WHEEL_COUNT_MAX = (1 << (COUNT_BITS_DEF - 1)) - 1;
    localparam longint  POS_MAX = 64'sd2147483647;
    localparam longint  POS_MIN = -64'sd2147483648;

    // atan(2^-i) in binary angle units
    localparam logic [31:0] ARCTAN_TURN [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [31:0]        heading;
    } pose_t;

    // shadow of the odometry state and registers
    logic [23:0] mm_per_count_q;
    logic [31:0] turn_gain_q;
    longint      wheel_count_q [4];
    longint      x_pos_q;
    longint      y_pos_q;
    logic [31:0] heading_q;

    pose_t pose_due_q [$];
    int    errors;
    bit    idle_on;     // random gaps on both sides
    int    hold_left;   // long receiver hold-off, in cycles
    int    rx_wait;

    // clock: 10 ns period
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // generous run limit
    initial
    begin
        #50ms;
        $display("four_wheel_omni_odometry verification failed");
        $finish;
    end

    // ---------------- prediction ----------------

    // floor(a*b / 2^30) on the full product
    function automatic longint mul_q30(input longint a, input longint b);
        logic signed [127:0] pa;
        logic signed [127:0] pb;
        logic signed [127:0] p;
        pa = a;
        pb = b;
        p  = pa * pb;
        return longint'(p >>> 30);
    endfunction

    function automatic longint clamp_pos(input longint v);
        if (v > POS_MAX)
            return POS_MAX;
        if (v < POS_MIN)
            return POS_MIN;
        return v;
    endfunction

    // rotation-mode CORDIC, Q2.30 cos/sin of a binary angle
    task automatic cordic_sincos(input logic [31:0] ang, output longint c, output longint s);
        logic [31:0] t;
        logic        flip;
        longint      x;
        longint      y;
        longint      z;
        longint      xs;
        longint      ys;
        t    = ang + QUARTER_TURN;
        flip = t[31];
        if (flip)
            ang = ang - 32'h8000_0000;
        z = longint'($signed(ang));
        x = longint'(CORDIC_K);
        y = 0;
        for (int i = 0; i < ANGLE_STEPS_DEF && i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ARCTAN_TURN[i]);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ARCTAN_TURN[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic odometry_update();
        longint              d [4];
        longint              d13;
        longint              d24;
        longint              c;
        longint              s;
        longint              dx;
        longint              dy;
        longint              diff;
        logic signed [127:0] pd;
        logic signed [127:0] pg;
        logic signed [127:0] p;
        for (int i = 0; i < 4; i++)
        begin
            d[i] = wheel_count_q[i] * longint'({40'd0, mm_per_count_q});
            if (i < 2)
                d[i] = -d[i];
        end
        d13 = (d[0] + d[2]) >>> 1;
        d24 = (d[1] + d[3]) >>> 1;
        cordic_sincos(heading_q + EIGHTH_TURN, c, s);
        dx = mul_q30(-d24, c) - mul_q30(d13, s);
        dy = mul_q30(-d13, c) + mul_q30(d24, s);
        x_pos_q = clamp_pos(x_pos_q + dx);
        y_pos_q = clamp_pos(y_pos_q + dy);
        diff = d[2] - d[0] + d[3] - d[1];
        pd = diff;
        pg = {96'd0, turn_gain_q};
        p  = pd * pg;
        heading_q = heading_q + p[55:24];
        for (int i = 0; i < 4; i++)
            wheel_count_q[i] = 0;
    endtask

    task automatic predict_pose(input logic m, input logic [1:0] w, input logic u);
        pose_t r;
        if (!m)
        begin
            if (u && wheel_count_q[w] < WHEEL_COUNT_MAX)
                wheel_count_q[w]++;
            else if (!u && wheel_count_q[w] > -WHEEL_COUNT_MAX - 1)
                wheel_count_q[w]--;
        end
        else
            odometry_update();
        r.pos_x   = x_pos_q[31:0];
        r.pos_y   = y_pos_q[31:0];
        r.heading = heading_q;
        pose_due_q.push_back(r);
    endtask

    // ---------------- driving ----------------

    // one input transaction; valid is left high so a back-to-back item
    // needs no second assignment in the same step
    task automatic send_item(input logic m, input logic [1:0] w, input logic u);
        int gap;
        gap = idle_on ? $urandom_range(0, 18) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        wheel    <= w;
        up       <= u;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_pose(m, w, u);
    endtask

    task automatic send_random_item(input int update_pct);
        send_item($urandom_range(0, 99) < update_pct, 2'($urandom), 1'($urandom));
    endtask

    // drop valid, wait out all outstanding poses, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pose_due_q.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_MM_PER_COUNT: mm_per_count_q = val[23:0];
            REG_TURN_GAIN:    turn_gain_q    = val;
            REG_START_X:      x_pos_q        = longint'($signed(val));
            REG_START_Y:      y_pos_q        = longint'($signed(val));
            default:          ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] mpc, input logic [31:0] gain,
                             input logic [31:0] sx, input logic [31:0] sy);
        write_reg(REG_MM_PER_COUNT, mpc);
        write_reg(REG_TURN_GAIN, gain);
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
    endtask

    // ---------------- receiver and checker ----------------

    // per-result random stall, plus the long hold-off when requested
    initial
    begin
        rx_wait = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (out_valid && out_ready)
            begin
                rx_wait = idle_on ? $urandom_range(0, 18) : 0;
                out_ready <= (rx_wait == 0);
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_ready <= (rx_wait == 0);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        pose_t exp_pose;
        if (rst_n && out_valid && out_ready)
        begin
            if (pose_due_q.size() == 0)
            begin
                $display("%0t: unexpected result transaction x=%0d y=%0d hdg=%h",
                         $time, pos_x, pos_y, heading);
                errors++;
            end
            else
            begin
                exp_pose = pose_due_q.pop_front();
                if (pos_x !== exp_pose.pos_x)
                begin
                    $display("%0t: pos_x expected %0d actual %0d", $time, exp_pose.pos_x, pos_x);
                    errors++;
                end
                if (pos_y !== exp_pose.pos_y)
                begin
                    $display("%0t: pos_y expected %0d actual %0d", $time, exp_pose.pos_y, pos_y);
                    errors++;
                end
                if (heading !== exp_pose.heading)
                begin
                    $display("%0t: heading expected %h actual %h", $time,
                             exp_pose.heading, heading);
                    errors++;
                end
            end
        end
    end

    // ---------------- tests ----------------

    // start pose, each wheel both ways, update ignoring wheel/up
    task automatic test_basic_moves();
        send_item(1'b1, 2'd0, 1'b0);
        for (int w = 0; w < 4; w++)
        begin
            send_item(1'b0, 2'(w), 1'b1);
            send_item(1'b0, 2'(w), 1'b1);
            send_item(1'b0, 2'(w), 1'b0);
        end
        send_item(1'b1, 2'd3, 1'b1);
        send_item(1'b0, 2'd2, 1'b1);
        send_item(1'b0, 2'd3, 1'b1);
        send_item(1'b1, 2'd1, 1'b0);
        drain();
    endtask

    // register extremes, a few moves under each
    task automatic test_register_sweep();
        for (int k = 0; k < 3; k++)
        begin
            case (k)
                0: write_all(32'd0, 32'd0, 32'h8000_0000, 32'h8000_0000);
                1: write_all(32'h00FF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
                default: write_all(32'd51472, 32'd174992640, 32'd0, 32'd0);
            endcase
            for (int i = 0; i < 12; i++)
                send_random_item(25);
            send_item(1'b1, 2'd0, 1'b0);
            drain();
        end
    endtask

    // long runs on single wheels, back to back, before one update
    task automatic test_count_run();
        idle_on = 1'b0;
        repeat (60)
            send_item(1'b0, 2'd2, 1'b1);
        repeat (64)
            send_item(1'b0, 2'd1, 1'b0);
        send_item(1'b1, 2'd0, 1'b0);
        drain();
        idle_on = 1'b1;
    endtask

    // big travel from each corner so the position clamps
    task automatic test_position_clamp();
        write_reg(REG_MM_PER_COUNT, 32'h00FF_FFFF);
        for (int k = 0; k < 4; k++)
        begin
            write_reg(REG_START_X, k[0] ? 32'h7FFF_0000 : 32'h8000_FFFF);
            write_reg(REG_START_Y, k[1] ? 32'h7FFF_0000 : 32'h8000_FFFF);
            repeat (25)
                send_item(1'b0, 2'($urandom_range(0, 3)), k[0] ^ k[1]);
            send_item(1'b1, 2'd0, 1'b0);
            repeat (25)
                send_item(1'b0, 2'($urandom_range(0, 3)), ~(k[0] ^ k[1]));
            send_item(1'b1, 2'd0, 1'b0);
            drain();
        end
    endtask

    // receiver stalls long while items keep coming
    task automatic test_output_stall();
        hold_left = 400;
        idle_on   = 1'b0;
        for (int i = 0; i < 16; i++)
            send_random_item(20);
        drain();
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [31:0] mpc;
        for (int blk = 0; blk < 5; blk++)
        begin
            mpc = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 70000);
            write_all(mpc, $urandom, $urandom, $urandom);
            idle_on = (blk != 2);
            for (int i = 0; i < 25; i++)
                send_random_item(15);
            drain();
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        errors    = 0;
        idle_on   = 1'b1;
        hold_left = 0;
        mm_per_count_q = MM_PER_COUNT_RST;
        turn_gain_q    = TURN_GAIN_RST;
        x_pos_q        = longint'($signed(START_X_RST));
        y_pos_q        = longint'($signed(START_Y_RST));
        heading_q      = '0;
        for (int i = 0; i < 4; i++)
            wheel_count_q[i] = 0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        mode      <= 1'b0;
        wheel     <= 2'd0;
        up        <= 1'b0;
        out_ready <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_moves();
        test_register_sweep();
        test_count_run();
        test_position_clamp();
        test_output_stall();
        test_random_traffic();

        if (errors == 0)
            $display("four_wheel_omni_odometry verification clean");
        else
            $display("four_wheel_omni_odometry verification failed");
        $finish;
    end
endmodule
`default_nettype wire

/* four_wheel_omni_odometry.f */
hdl/fwo_pkg.sv
hdl/fwo_mult.sv
hdl/fwo_ctrl.sv
hdl/fwo_datapath.sv
hdl/four_wheel_omni_odometry.sv
dv/four_wheel_omni_odometry_test.sv
